// ===== hw/rtl/ipcp_pkg.sv =====
// Types and constants shared by the IPv4 CIDR text parser.
// No dependencies.
package ipcp_pkg;

    localparam int ADDR_BUFFER = 40;
    localparam int CNT_W       = $clog2(ADDR_BUFFER);
    localparam logic [CNT_W-1:0] ADDR_CNT_MAX = CNT_W'(ADDR_BUFFER - 1);

    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CH_DOT   = 8'h2E;
    localparam logic [7:0]  CH_SLASH = 8'h2F;

    localparam logic [8:0]  OCTET_MAX      = 9'd255;
    localparam logic [11:0] OCTET_SAT      = 12'd256;
    localparam logic [5:0]  DEFAULT_PREFIX = 6'd24;
    localparam logic [5:0]  FULL_PREFIX    = 6'd32;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_ADDR   = 2'b01,
        PH_PREFIX = 2'b10
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_req;
    } t_req;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] address;
        logic [31:0] netmask;
        logic [5:0]  prefix_len;
    } t_res;

    typedef struct packed {
        t_phase           phase;
        logic [1:0]       octet_index;
        logic [8:0]       octet_value;
        logic             octet_has_digit;
        logic [23:0]      done_octets;
        logic [CNT_W-1:0] addr_char_count;
        logic [5:0]       prefix_value;
        logic             prefix_has_digit;
        logic             error_seen;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:            PH_ADDR,
        octet_index:      2'd0,
        octet_value:      9'd0,
        octet_has_digit:  1'b0,
        done_octets:      24'd0,
        addr_char_count:  '0,
        prefix_value:     6'd0,
        prefix_has_digit: 1'b0,
        error_seen:       1'b0
    };

endpackage

// ===== hw/rtl/ipcp_step.sv =====
// One parser step: next state and result for one request.
// Depends on ipcp_pkg.
module ipcp_step (
    input  ipcp_pkg::t_state i_state,
    input  ipcp_pkg::t_req   i_req,
    output ipcp_pkg::t_state o_state,
    output ipcp_pkg::t_res   o_res
);

    logic [3:0]  w_digit;
    logic        w_is_digit;
    logic [11:0] w_oct_sum;
    logic [8:0]  w_pre_sum;
    logic        w_ok;
    logic [5:0]  w_plen;

    assign w_digit    = 4'(i_req.ch - ipcp_pkg::CH_ZERO);
    assign w_is_digit = i_req.ch inside {[ipcp_pkg::CH_ZERO:ipcp_pkg::CH_NINE]};
    assign w_oct_sum  = {3'd0, i_state.octet_value} * 12'd10 + {8'd0, w_digit};
    assign w_pre_sum  = {3'd0, i_state.prefix_value} * 9'd10 + {5'd0, w_digit};

    assign w_ok = !i_state.error_seen && i_state.octet_has_digit
               && (i_state.octet_value <= ipcp_pkg::OCTET_MAX)
               && (i_state.octet_index >= 2'd2)
               && !(i_state.phase == ipcp_pkg::PH_PREFIX && !i_state.prefix_has_digit);

    assign w_plen = (i_state.phase == ipcp_pkg::PH_PREFIX) ? i_state.prefix_value
                                                           : ipcp_pkg::DEFAULT_PREFIX;

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        if (i_req.end_req) begin
            o_state = ipcp_pkg::ST_RESET;
            if (w_ok) begin
                o_res.valid_res  = 1'b1;
                o_res.prefix_len = w_plen;
                o_res.netmask    = ~(ipcp_pkg::ALL_ONES >> w_plen);
                if (i_state.octet_index == 2'd3) begin
                    o_res.address = {i_state.done_octets, i_state.octet_value[7:0]};
                end else begin
                    o_res.address = {i_state.done_octets[15:0],
                                     i_state.octet_value[7:0], 8'h00};
                end
            end
        end else if (!i_state.error_seen) begin
            case (i_state.phase)
                ipcp_pkg::PH_ADDR: begin
                    if (i_req.ch == ipcp_pkg::CH_SLASH) begin
                        o_state.phase = ipcp_pkg::PH_PREFIX;
                    end else if (i_state.addr_char_count >= ipcp_pkg::ADDR_CNT_MAX) begin
                        o_state.error_seen = 1'b1;
                    end else begin
                        o_state.addr_char_count = i_state.addr_char_count + 1'b1;
                        if (w_is_digit) begin
                            o_state.octet_value = (w_oct_sum > ipcp_pkg::OCTET_SAT)
                                ? ipcp_pkg::OCTET_SAT[8:0] : w_oct_sum[8:0];
                            o_state.octet_has_digit = 1'b1;
                        end else if (i_req.ch == ipcp_pkg::CH_DOT) begin
                            if (!i_state.octet_has_digit || i_state.octet_index == 2'd3
                                || i_state.octet_value > ipcp_pkg::OCTET_MAX) begin
                                o_state.error_seen = 1'b1;
                            end else begin
                                o_state.done_octets = {i_state.done_octets[15:0],
                                                       i_state.octet_value[7:0]};
                                o_state.octet_index     = i_state.octet_index + 2'd1;
                                o_state.octet_value     = 9'd0;
                                o_state.octet_has_digit = 1'b0;
                            end
                        end else begin
                            o_state.error_seen = 1'b1;
                        end
                    end
                end
                ipcp_pkg::PH_PREFIX: begin
                    if (!w_is_digit || w_pre_sum > {3'd0, ipcp_pkg::FULL_PREFIX}) begin
                        o_state.error_seen = 1'b1;
                    end else begin
                        o_state.prefix_value     = w_pre_sum[5:0];
                        o_state.prefix_has_digit = 1'b1;
                    end
                end
                default: begin
                    o_state.error_seen = 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/ipcp_out_stage.sv =====
// Result register with valid/ready handshake toward the consumer.
// Depends on ipcp_pkg.
module ipcp_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  ipcp_pkg::t_res i_res,
    input  logic           i_res_ready,
    output logic           o_space,
    output logic           o_res_valid,
    output ipcp_pkg::t_res o_res
);

    logic           r_vld;
    ipcp_pkg::t_res r_res;

    assign o_space     = !r_vld || i_res_ready;
    assign o_res_valid = r_vld;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== hw/rtl/ipv4_cidr_text_parser.sv =====
// IPv4 CIDR text parser: one character per request, result on the terminator.
// A terminator is held in the input register until the result register has space, then its result is loaded there.
// Throughput: one request per cycle; a stalled result holds a terminator, and the requests behind it wait.
// A single step stage lies between the input and result registers.
// Reset (synchronous, active low) clears both valids and the parser state.
// Depends on ipcp_pkg, ipcp_step, ipcp_out_stage.
module ipv4_cidr_text_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  ipcp_pkg::t_req   i_req,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output ipcp_pkg::t_res   o_res
);

    logic             r_in_vld;
    ipcp_pkg::t_req   r_in;
    ipcp_pkg::t_state r_st;
    ipcp_pkg::t_state n_st;
    ipcp_pkg::t_res   w_res;
    logic             w_space;
    logic             w_adv;
    logic             w_load;

    assign w_adv       = r_in_vld && (!r_in.end_req || w_space);
    assign w_load      = w_adv && r_in.end_req;
    assign o_req_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_req_ready) begin
            r_in_vld <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ipcp_pkg::ST_RESET;
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    ipcp_step u_step (
        .i_state (r_st),
        .i_req   (r_in),
        .o_state (n_st),
        .o_res   (w_res)
    );

    ipcp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_res       (w_res),
        .i_res_ready (i_res_ready),
        .o_space     (w_space),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

`ifndef SYNTHESIS
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_st.phase == ipcp_pkg::PH_ADDR && r_st.addr_char_count == '0
                    && !r_st.error_seen && r_st.octet_index == 2'd0))
        else $error("parser state not cleared after terminator");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.valid_res) |-> (o_res.address == 32'd0
            && o_res.netmask == 32'd0 && o_res.prefix_len == 6'd0))
        else $error("invalid result carries nonzero fields");

    a_prefix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.valid_res) |-> (o_res.prefix_len <= ipcp_pkg::FULL_PREFIX
            && o_res.netmask == ~(ipcp_pkg::ALL_ONES >> o_res.prefix_len)))
        else $error("prefix length or mask out of range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.addr_char_count <= ipcp_pkg::ADDR_CNT_MAX)
        else $error("address character count overflow");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.error_seen && !w_load) |=> r_st.error_seen)
        else $error("error flag dropped before terminator");
`endif

endmodule
